### design/dsi_dcs_read_response_parser_assert.svh
// Assertion macros for the DCS read response parser.
// The clocked form disables checking while reset is asserted; the plain form runs always.
`ifndef DSI_DCS_READ_RESPONSE_PARSER_ASSERT_SVH
`define DSI_DCS_READ_RESPONSE_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define DSIDCS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DSIDCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DSIDCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define DSIDCS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### design/dsidcs_pkg.sv
`default_nettype none
package dsidcs_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_WORD  = 2'd1;
  localparam logic [1:0] OP_EMPTY = 2'd2;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_BYTE   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_LEN  = 3'd1;
  localparam logic [2:0] ST_BUSY     = 3'd2;
  localparam logic [2:0] ST_NO_DATA  = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;
  localparam logic [2:0] ST_PROTOCOL = 3'd5;
  localparam logic [2:0] ST_OVERFLOW = 3'd6;

  localparam logic [7:0] DT_SET_MAX_RET = 8'h37;
  localparam logic [7:0] DT_DCS_READ    = 8'h06;
  localparam logic [5:0] DT_SHORT_1     = 6'h21;
  localparam logic [5:0] DT_SHORT_2     = 6'h22;
  localparam logic [5:0] DT_LONG        = 6'h1c;

  localparam logic [2:0] TRAILER_LIMIT = 3'd4;
  localparam int         BATCH_MAX     = 4;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PAYLOAD,
    PH_TRAILER
  } phase_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  dcs_command;
    logic [7:0]  request_length;
    logic        fifo_was_empty;
    logic [31:0] rx_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] tx_word;
    logic [7:0]  data_byte;
    logic [3:0]  byte_index;
    logic [2:0]  status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [2:0]                    count;
    out_item_t [BATCH_MAX-1:0]     res;
  } batch_t;

endpackage
`default_nettype wire

### design/dsidcs_parse.sv
`default_nettype none
module dsidcs_parse
  import dsidcs_pkg::*;
#(
  parameter int MAX_READ_BYTES = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t item,
  input  wire logic     fire,
  output batch_t        batch
);

  localparam int CW0   = $clog2(MAX_READ_BYTES + 1);
  localparam int CNT_W = (CW0 < 2) ? 2 : CW0;
  localparam logic [7:0]  MAX_LEN8  = 8'(MAX_READ_BYTES);
  localparam logic [15:0] MAX_CNT16 = 16'(MAX_READ_BYTES);

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   exp_len_r, exp_len_nxt;
  logic [CNT_W-1:0]   resp_cnt_r, resp_cnt_nxt;
  logic [CNT_W-1:0]   bytes_r, bytes_nxt;
  logic [2:0]         trailer_r, trailer_nxt;

  logic [5:0]         dtype;
  logic [15:0]        word_cnt;
  logic [CNT_W-1:0]   remain;
  logic [2:0]         nbytes;
  logic [CNT_W-1:0]   bytes_after;
  logic               bad_len;

  assign dtype       = item.rx_word[5:0];
  assign word_cnt    = item.rx_word[23:8];
  assign remain      = resp_cnt_r - bytes_r;
  assign nbytes      = (remain >= 4) ? 3'd4 : 3'(remain);
  assign bytes_after = bytes_r + CNT_W'(nbytes);
  assign bad_len     = (item.request_length == 8'd0) || (item.request_length > MAX_LEN8);

  always_comb begin
    phase_nxt    = phase_r;
    exp_len_nxt  = exp_len_r;
    resp_cnt_nxt = resp_cnt_r;
    bytes_nxt    = bytes_r;
    trailer_nxt  = trailer_r;
    case (item.operation)
      OP_START: begin
        if (bad_len || !item.fifo_was_empty) begin
          phase_nxt = PH_IDLE;
        end else begin
          phase_nxt    = PH_HEADER;
          exp_len_nxt  = item.request_length[CNT_W-1:0];
          resp_cnt_nxt = '0;
          bytes_nxt    = '0;
          trailer_nxt  = '0;
        end
      end
      OP_WORD: begin
        case (phase_r)
          PH_HEADER: begin
            if (dtype == DT_SHORT_1 || dtype == DT_SHORT_2) begin
              resp_cnt_nxt = (dtype == DT_SHORT_1) ? CNT_W'(1) : CNT_W'(2);
              bytes_nxt    = resp_cnt_nxt;
              trailer_nxt  = '0;
              phase_nxt    = PH_TRAILER;
            end else if (dtype == DT_LONG) begin
              if (word_cnt == 16'd0 || word_cnt > MAX_CNT16) begin
                phase_nxt = PH_IDLE;
              end else begin
                resp_cnt_nxt = word_cnt[CNT_W-1:0];
                bytes_nxt    = '0;
                phase_nxt    = PH_PAYLOAD;
              end
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_PAYLOAD: begin
            bytes_nxt = bytes_after;
            if (bytes_after >= resp_cnt_r) begin
              trailer_nxt = '0;
              phase_nxt   = PH_TRAILER;
            end
          end
          PH_TRAILER: begin
            trailer_nxt = trailer_r + 3'd1;
            if (trailer_nxt > TRAILER_LIMIT) begin
              phase_nxt = PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      OP_EMPTY: begin
        if (phase_r != PH_IDLE) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    batch = '0;
    case (item.operation)
      OP_START: begin
        if (bad_len) begin
          batch.count                = 3'd1;
          batch.res[0].result_kind   = KIND_STATUS;
          batch.res[0].status        = ST_BAD_LEN;
        end else if (!item.fifo_was_empty) begin
          batch.count                = 3'd1;
          batch.res[0].result_kind   = KIND_STATUS;
          batch.res[0].status        = ST_BUSY;
        end else begin
          batch.count                = 3'd2;
          batch.res[0].result_kind   = KIND_TX;
          batch.res[0].tx_word       = {16'h0000, item.request_length, DT_SET_MAX_RET};
          batch.res[1].result_kind   = KIND_TX;
          batch.res[1].tx_word       = {7'd0, 1'b1, 8'h00, item.dcs_command, DT_DCS_READ};
        end
      end
      OP_WORD: begin
        case (phase_r)
          PH_HEADER: begin
            if (dtype == DT_SHORT_1 || dtype == DT_SHORT_2) begin
              batch.count                = (dtype == DT_SHORT_1) ? 3'd1 : 3'd2;
              batch.res[0].result_kind   = KIND_BYTE;
              batch.res[0].data_byte     = item.rx_word[15:8];
              batch.res[0].byte_index    = 4'd0;
              if (dtype == DT_SHORT_2) begin
                batch.res[1].result_kind = KIND_BYTE;
                batch.res[1].data_byte   = item.rx_word[23:16];
                batch.res[1].byte_index  = 4'd1;
              end
            end else if (dtype == DT_LONG) begin
              if (word_cnt == 16'd0 || word_cnt > MAX_CNT16) begin
                batch.count              = 3'd1;
                batch.res[0].result_kind = KIND_STATUS;
                batch.res[0].status      = ST_MISMATCH;
              end
            end else begin
              batch.count                = 3'd1;
              batch.res[0].result_kind   = KIND_STATUS;
              batch.res[0].status        = ST_PROTOCOL;
            end
          end
          PH_PAYLOAD: begin
            batch.count = nbytes;
            for (int i = 0; i < BATCH_MAX; i++) begin
              if (3'(i) < nbytes) begin
                batch.res[2'(i)].result_kind = KIND_BYTE;
                batch.res[2'(i)].data_byte   = item.rx_word[5'(8*i) +: 8];
                batch.res[2'(i)].byte_index  = 4'(8'(bytes_r) + 8'(i));
              end
            end
          end
          PH_TRAILER: begin
            if (trailer_r + 3'd1 > TRAILER_LIMIT) begin
              batch.count                = 3'd1;
              batch.res[0].result_kind   = KIND_STATUS;
              batch.res[0].status        = ST_OVERFLOW;
            end
          end
          default: begin
          end
        endcase
      end
      OP_EMPTY: begin
        if (phase_r == PH_HEADER || phase_r == PH_PAYLOAD) begin
          batch.count                = 3'd1;
          batch.res[0].result_kind   = KIND_STATUS;
          batch.res[0].status        = ST_NO_DATA;
        end else if (phase_r == PH_TRAILER) begin
          batch.count                = 3'd1;
          batch.res[0].result_kind   = KIND_STATUS;
          batch.res[0].status        = (resp_cnt_r == exp_len_r) ? ST_OK : ST_MISMATCH;
        end
      end
      default: begin
      end
    endcase
    for (int i = 0; i < BATCH_MAX; i++) begin
      if (3'(i) + 3'd1 == batch.count) begin
        batch.res[2'(i)].last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      exp_len_r  <= '0;
      resp_cnt_r <= '0;
      bytes_r    <= '0;
      trailer_r  <= '0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      exp_len_r  <= exp_len_nxt;
      resp_cnt_r <= resp_cnt_nxt;
      bytes_r    <= bytes_nxt;
      trailer_r  <= trailer_nxt;
    end
  end

endmodule
`default_nettype wire

### design/dsidcs_outbuf.sv
`default_nettype none
module dsidcs_outbuf
  import dsidcs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire batch_t batch,
  input  wire logic   fire,
  output logic        buf_ready,
  output logic        out_valid,
  input  wire logic   out_stall,
  output out_item_t   out_data
);

  out_item_t [BATCH_MAX-1:0] ent_r;
  logic [2:0]                pend_r;
  logic [1:0]                ptr_r;

  assign out_valid = (pend_r != 3'd0);
  assign buf_ready = (pend_r == 3'd0) || (pend_r == 3'd1 && !out_stall);
  assign out_data  = ent_r[ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'd0;
      ptr_r  <= 2'd0;
    end else if (fire) begin
      pend_r <= batch.count;
      ptr_r  <= 2'd0;
    end else if (out_valid && !out_stall) begin
      pend_r <= pend_r - 3'd1;
      ptr_r  <= ptr_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ent_r <= batch.res;
    end
  end

endmodule
`default_nettype wire

### design/dsi_dcs_read_response_parser.sv
// DCS read response parser.
// The input channel (in_valid, in_stall, in_data) carries one request at a time:
// start a read, a word popped from the receive FIFO, or a note that the FIFO was empty.
// The result channel (out_valid, out_stall, out_data) returns transmit header words,
// received data bytes and a final status; out_data.last marks the final result
// of each request that yields any.
// A request is held in an input register and, once the result buffer can take it, decoded
// into that buffer of up to four results, which drain one per cycle while out_stall is low.
// Each request passes the input register and then the buffer register before its first result shows.
// Results leave through a single result port: a start yields two results (one status on
// error), a long read payload word up to four. The buffer takes the next request's results
// only when it is empty or as its last pending result leaves.
// Synchronous reset returns the parser to idle and empties both the input register
// and the result buffer.
// While the receiver stalls, the buffered result holds, and the input register holds
// the next request and raises in_stall until the buffer can take its results.
`default_nettype none
`include "dsi_dcs_read_response_parser_assert.svh"
module dsi_dcs_read_response_parser
  import dsidcs_pkg::*;
#(
  parameter int MAX_READ_BYTES = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  in_item_t item_r;
  logic     full_r;
  logic     buf_ready;
  logic     fire;
  batch_t   batch;

  assign fire     = full_r && buf_ready;
  assign in_stall = full_r && !buf_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      full_r <= 1'b1;
    end else if (fire) begin
      full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

  dsidcs_parse #(
    .MAX_READ_BYTES(MAX_READ_BYTES)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item_r),
    .fire  (fire),
    .batch (batch)
  );

  dsidcs_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .batch     (batch),
    .fire      (fire),
    .buf_ready (buf_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `DSIDCS_ASSERT(a_drain_when_empty, clk, rst_n, (full_r && !out_valid) |-> !in_stall, "held request not taken by empty result buffer")
  `DSIDCS_ASSERT(a_last_frees_buffer, clk, rst_n, (out_valid && !out_stall && out_data.last) |-> buf_ready, "last result delivered but buffer not free")
  `DSIDCS_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> (!out_valid && !in_stall), "outputs active after reset")

endmodule
`default_nettype wire
